>>> src/nixie_multiplex_scanner_defines.svh
// Assertion helpers used by the scan core RTL.
`ifndef NIXIE_MULTIPLEX_SCANNER_DEFINES_SVH
`define NIXIE_MULTIPLEX_SCANNER_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define NMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define NMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/nms_pkg.sv
`default_nettype none

package nms_pkg;

  localparam int unsigned TubeCountDefault = 4;
  localparam int unsigned WaitW            = 16;
  localparam int unsigned CfgIdxW          = 2;
  localparam int unsigned AnodePins        = 4;

  localparam logic [WaitW-1:0] CathodeOnReset = 16'd100;
  localparam logic [WaitW-1:0] AnodeOnReset   = 16'd100;
  localparam logic [WaitW-1:0] AnodeOffReset  = 16'd1000;
  localparam logic [WaitW-1:0] BlankReset     = 16'd100;

  localparam logic [3:0] CodeBlank = 4'hF;
  localparam logic [3:0] MaxValue  = 4'd10;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_SET   = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CATHODE_ON = 2'd0,
    CFG_ANODE_ON   = 2'd1,
    CFG_ANODE_OFF  = 2'd2,
    CFG_BLANK      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] digit_index;
    logic [3:0] digit_value;
    logic       point_on;
  } cmd_t;

  typedef struct packed {
    logic [WaitW-1:0] cathode_on_wait;
    logic [WaitW-1:0] anode_on_wait;
    logic [WaitW-1:0] anode_off_wait;
    logic [WaitW-1:0] blank_wait;
  } cfg_t;

  // numeral to cathode driver code
  function automatic logic [3:0] digit_code(logic [3:0] value);
    logic [3:0] code;
    case (value)
      4'd0:    code = 4'h5;
      4'd1:    code = 4'h7;
      4'd2:    code = 4'h9;
      4'd3:    code = 4'h2;
      4'd4:    code = 4'h3;
      4'd5:    code = 4'h0;
      4'd6:    code = 4'h4;
      4'd7:    code = 4'h1;
      4'd8:    code = 4'h6;
      4'd9:    code = 4'h8;
      default: code = CodeBlank;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> src/nms_cmd_if.sv
`default_nettype none

interface nms_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [1:0] digit_index;
  logic [3:0] digit_value;
  logic       point_on;

  modport source (output valid, command, digit_index, digit_value, point_on, input ready);
  modport sink   (input valid, command, digit_index, digit_value, point_on, output ready);
endinterface

`default_nettype wire

>>> src/nms_res_if.sv
`default_nettype none

interface nms_res_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic       converter_enable;
  logic [3:0] cathode_code;
  logic [3:0] anode_enables;
  logic       point_pin;

  modport source (output valid, status, converter_enable, cathode_code, anode_enables,
                  point_pin, input ready);
  modport sink   (input valid, status, converter_enable, cathode_code, anode_enables,
                  point_pin, output ready);
endinterface

`default_nettype wire

>>> src/nms_in_stage.sv
`default_nettype none

module nms_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire nms_pkg::cmd_t in_cmd_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output nms_pkg::cmd_t      out_cmd_o
);
  import nms_pkg::*;

  logic valid_q;
  cmd_t cmd_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_cmd_o   = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= in_cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> src/nms_cfg_regs.sv
`default_nettype none

module nms_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [nms_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [nms_pkg::WaitW-1:0]     cfg_data_i,
  input  wire logic                          idle_i,
  output nms_pkg::cfg_t                      cfg_o
);
  import nms_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_o = cfg_q;

  // writes are dropped unless the scanner is idle
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i && idle_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CATHODE_ON: cfg_d.cathode_on_wait = cfg_data_i;
        CFG_ANODE_ON:   cfg_d.anode_on_wait   = cfg_data_i;
        CFG_ANODE_OFF:  cfg_d.anode_off_wait  = cfg_data_i;
        CFG_BLANK:      cfg_d.blank_wait      = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cathode_on_wait <= CathodeOnReset;
      cfg_q.anode_on_wait   <= AnodeOnReset;
      cfg_q.anode_off_wait  <= AnodeOffReset;
      cfg_q.blank_wait      <= BlankReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

>>> src/nms_scan_core.sv
`default_nettype none
`include "nixie_multiplex_scanner_defines.svh"

module nms_scan_core #(
  parameter int unsigned TUBE_COUNT = nms_pkg::TubeCountDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire nms_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire nms_pkg::cmd_t in_cmd_i,
  output logic               idle_o,
  nms_res_if.source          res
);
  import nms_pkg::*;

  localparam int unsigned TubeW = (TUBE_COUNT > 1) ? $clog2(TUBE_COUNT) : 1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_STARTUP,
    PH_SCAN
  } phase_e;

  typedef enum logic [1:0] {
    ST_CATHODE,
    ST_ANODE_ON,
    ST_ANODE_OFF,
    ST_BLANK
  } step_e;

  phase_e                 phase_q, phase_d;
  step_e                  step_q, step_d;
  logic [TubeW-1:0]       tube_q, tube_d;
  logic [WaitW-1:0]       count_q, count_d;
  logic [4:0]             digits_q [TUBE_COUNT];
  logic [4:0]             digits_d [TUBE_COUNT];
  logic                   conv_q, conv_d;
  logic [3:0]             cath_q, cath_d;
  logic [TUBE_COUNT-1:0]  anodes_q, anodes_d;
  logic                   point_q, point_d;

  logic                   out_valid_q, out_valid_d;
  logic                   status_q, status_d;
  logic                   fire;
  logic [4:0]             cur_digit;
  logic [3:0]             anode_pins;

  assign in_ready_o = !out_valid_q || res.ready;
  assign fire       = in_valid_i && in_ready_o;
  assign idle_o     = (phase_q == PH_IDLE);
  assign cur_digit  = digits_q[tube_q];

  always_comb begin
    phase_d     = phase_q;
    step_d      = step_q;
    tube_d      = tube_q;
    count_d     = count_q;
    digits_d    = digits_q;
    conv_d      = conv_q;
    cath_d      = cath_q;
    anodes_d    = anodes_q;
    point_d     = point_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;

    if (res.ready) begin
      out_valid_d = 1'b0;
    end

    if (fire) begin
      out_valid_d = 1'b1;
      status_d    = 1'b0;
      case (cmd_e'(in_cmd_i.command))
        CMD_TICK: begin
          case (phase_q)
            PH_IDLE: ;
            PH_STARTUP: begin
              count_d = cfg_i.cathode_on_wait;
              conv_d  = 1'b1;
              phase_d = PH_SCAN;
              tube_d  = '0;
              step_d  = ST_CATHODE;
            end
            PH_SCAN: begin
              if (count_q <= WaitW'(1)) begin
                case (step_q)
                  ST_CATHODE: begin
                    count_d = cfg_i.anode_on_wait;
                    cath_d  = cur_digit[3:0];
                    step_d  = ST_ANODE_ON;
                  end
                  ST_ANODE_ON: begin
                    count_d          = cfg_i.anode_off_wait;
                    anodes_d[tube_q] = 1'b1;
                    if (cur_digit[4]) begin
                      point_d = 1'b1;
                    end
                    step_d = ST_ANODE_OFF;
                  end
                  ST_ANODE_OFF: begin
                    count_d          = cfg_i.blank_wait;
                    anodes_d[tube_q] = 1'b0;
                    point_d          = 1'b0;
                    step_d           = ST_BLANK;
                  end
                  ST_BLANK: begin
                    count_d = cfg_i.cathode_on_wait;
                    cath_d  = CodeBlank;
                    step_d  = ST_CATHODE;
                    if (tube_q == TubeW'(TUBE_COUNT - 1)) begin
                      tube_d = '0;
                    end else begin
                      tube_d = tube_q + TubeW'(1);
                    end
                  end
                  default: ;
                endcase
              end else begin
                count_d = count_q - WaitW'(1);
              end
            end
            default: ;
          endcase
        end
        CMD_START: begin
          if (phase_q != PH_IDLE) begin
            status_d = 1'b1;
          end else begin
            for (int i = 0; i < TUBE_COUNT; i++) begin
              digits_d[i] = {1'b0, CodeBlank};
            end
            phase_d = PH_STARTUP;
          end
        end
        CMD_STOP: begin
          if (phase_q == PH_IDLE) begin
            status_d = 1'b1;
          end else begin
            for (int i = 0; i < TUBE_COUNT; i++) begin
              digits_d[i] = {1'b0, CodeBlank};
            end
            conv_d   = 1'b0;
            cath_d   = '0;
            anodes_d = '0;
            point_d  = 1'b0;
            count_d  = '0;
            phase_d  = PH_IDLE;
          end
        end
        CMD_SET: begin
          if ((4'(in_cmd_i.digit_index) >= 4'(TUBE_COUNT)) ||
              (in_cmd_i.digit_value > MaxValue)) begin
            status_d = 1'b1;
          end else begin
            for (int i = 0; i < TUBE_COUNT; i++) begin
              if (4'(in_cmd_i.digit_index) == 4'(i)) begin
                digits_d[i] = {in_cmd_i.point_on, digit_code(in_cmd_i.digit_value)};
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      step_q      <= ST_CATHODE;
      tube_q      <= '0;
      count_q     <= '0;
      for (int i = 0; i < TUBE_COUNT; i++) begin
        digits_q[i] <= {1'b0, CodeBlank};
      end
      conv_q      <= 1'b0;
      cath_q      <= '0;
      anodes_q    <= '0;
      point_q     <= 1'b0;
      status_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      step_q      <= step_d;
      tube_q      <= tube_d;
      count_q     <= count_d;
      digits_q    <= digits_d;
      conv_q      <= conv_d;
      cath_q      <= cath_d;
      anodes_q    <= anodes_d;
      point_q     <= point_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  // tubes above the fourth have no pin
  always_comb begin
    anode_pins = '0;
    for (int i = 0; i < AnodePins; i++) begin
      if (i < TUBE_COUNT) begin
        anode_pins[i] = anodes_q[i];
      end
    end
  end

  assign res.valid            = out_valid_q;
  assign res.status           = status_q;
  assign res.converter_enable = conv_q;
  assign res.cathode_code     = cath_q;
  assign res.anode_enables    = anode_pins;
  assign res.point_pin        = point_q;

  `NMS_ASSERT(a_one_anode, $onehot0(anodes_q), "more than one anode lit")
  `NMS_ASSERT(a_idle_dark, !idle_o || (!conv_q && anodes_q == '0 && !point_q),
              "pins driven while idle")
  `NMS_ASSERT(a_point_lit, !point_q || anodes_q != '0, "point lit without anode")
  `NMS_ASSERT_NEXT(a_stop_idle, fire && in_cmd_i.command == CMD_STOP, phase_q == PH_IDLE,
                   "stop did not return to idle")

endmodule

`default_nettype wire

>>> src/nixie_multiplex_scanner.sv
// Scan controller for a row of multiplexed nixie tubes.
// Command channel (cmd_if): tick, start, stop or set digit with index, value
// and point. Each command transfer yields exactly one result transfer on
// res_if: a reject flag plus the converter, cathode, anode and point levels
// as they stand after the command.
// While scanning, each tube runs four timed phases counted in tick commands:
// cathode on, anode on, anode off, blank; then the next tube follows.
// Configuration: cfg_we_i, cfg_idx_i and cfg_data_i set the four phase
// lengths; writes are ignored unless the scanner is stopped.
// A command passes through the input register, then the result register.
// Throughput: one command per cycle while res_if.ready stays high, as the
// scan state is updated for each command as it is taken.
// Reset: scanner stopped, all pins low, digits blank, phase lengths at
// their defaults.
// A stalled receiver holds the result; one further command waits in the
// input register, after which cmd_if.ready drops.
`default_nettype none

module nixie_multiplex_scanner #(
  parameter int unsigned TUBE_COUNT = nms_pkg::TubeCountDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  nms_cmd_if.sink                          cmd_if,
  nms_res_if.source                        res_if,
  input  wire logic                        cfg_we_i,
  input  wire logic [nms_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [nms_pkg::WaitW-1:0]   cfg_data_i
);
  import nms_pkg::*;

  cmd_t in_cmd;
  cmd_t stage_cmd;
  cfg_t cfg;
  logic stage_valid;
  logic core_ready;
  logic idle;

  assign in_cmd.command     = cmd_if.command;
  assign in_cmd.digit_index = cmd_if.digit_index;
  assign in_cmd.digit_value = cmd_if.digit_value;
  assign in_cmd.point_on    = cmd_if.point_on;

  nms_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_if.valid),
    .in_ready_o  (cmd_if.ready),
    .in_cmd_i    (in_cmd),
    .out_valid_o (stage_valid),
    .out_ready_i (core_ready),
    .out_cmd_o   (stage_cmd)
  );

  nms_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .idle_i     (idle),
    .cfg_o      (cfg)
  );

  nms_scan_core #(
    .TUBE_COUNT (TUBE_COUNT)
  ) u_scan_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (stage_valid),
    .in_ready_o (core_ready),
    .in_cmd_i   (stage_cmd),
    .idle_o     (idle),
    .res        (res_if)
  );

endmodule

`default_nettype wire

>>> verif/nms_scan_checker.sv
module nms_scan_checker #(
  parameter int unsigned TubeCount = nms_pkg::TubeCountDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  nms_cmd_if                          cmd_mon,
  nms_res_if                          res_mon,
  input  logic                        cfg_we_i,
  input  logic [nms_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [nms_pkg::WaitW-1:0]   cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          compared_o
);
  import nms_pkg::*;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_ARMED,
    SCAN_RUN
  } scan_mode_e;

  typedef enum logic [1:0] {
    STEP_CATHODE,
    STEP_ANODE_ON,
    STEP_ANODE_OFF,
    STEP_BLANK
  } tube_step_e;

  typedef struct packed {
    logic                 status;
    logic                 converter;
    logic [3:0]           cathode;
    logic [AnodePins-1:0] anodes;
    logic                 point;
  } scan_pins_t;

  // numeral n sits at bits 4n+3..4n
  localparam logic [43:0] CathodeMap = {
    4'hF, 4'h8, 4'h6, 4'h1, 4'h4, 4'h0, 4'h3, 4'h2, 4'h9, 4'h7, 4'h5
  };

  logic [WaitW-1:0]     wait_cathode, wait_anode_on, wait_anode_off, wait_blank;
  scan_mode_e           mode;
  tube_step_e           step_now;
  int unsigned          tube;
  logic [WaitW-1:0]     countdown;
  logic [4:0]           digit_codes [TubeCount];
  logic                 pin_conv;
  logic [3:0]           pin_cathode;
  logic [AnodePins-1:0] pin_anodes;
  logic                 pin_point;
  scan_pins_t           due_pins_q [$];

  function automatic void blank_digits();
    for (int unsigned i = 0; i < TubeCount; i++) digit_codes[i] = {1'b0, CodeBlank};
  endfunction

  function automatic void reset_scanner();
    wait_cathode   = CathodeOnReset;
    wait_anode_on  = AnodeOnReset;
    wait_anode_off = AnodeOffReset;
    wait_blank     = BlankReset;
    mode           = SCAN_IDLE;
    step_now       = STEP_CATHODE;
    tube           = 0;
    countdown      = '0;
    pin_conv       = 1'b0;
    pin_cathode    = '0;
    pin_anodes     = '0;
    pin_point      = 1'b0;
    blank_digits();
  endfunction

  function automatic void phase_expired();
    case (step_now)
      STEP_CATHODE: begin
        countdown   = wait_anode_on;
        pin_cathode = digit_codes[tube][3:0];
        step_now    = STEP_ANODE_ON;
      end
      STEP_ANODE_ON: begin
        countdown        = wait_anode_off;
        pin_anodes[tube] = 1'b1;
        if (digit_codes[tube][4]) pin_point = 1'b1;
        step_now = STEP_ANODE_OFF;
      end
      STEP_ANODE_OFF: begin
        countdown        = wait_blank;
        pin_anodes[tube] = 1'b0;
        pin_point        = 1'b0;
        step_now         = STEP_BLANK;
      end
      default: begin
        countdown   = wait_cathode;
        pin_cathode = CodeBlank;
        tube        = (tube + 1) % TubeCount;
        step_now    = STEP_CATHODE;
      end
    endcase
  endfunction

  function automatic void tick_scanner();
    case (mode)
      SCAN_ARMED: begin
        countdown = wait_cathode;
        pin_conv  = 1'b1;
        mode      = SCAN_RUN;
        tube      = 0;
        step_now  = STEP_CATHODE;
      end
      SCAN_RUN: begin
        if (countdown <= 16'd1) begin
          countdown = '0;
          phase_expired();
        end else begin
          countdown = countdown - 16'd1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic scan_pins_t advance_scanner(input cmd_t c);
    scan_pins_t r;
    r.status = 1'b0;
    case (cmd_e'(c.command))
      CMD_TICK: tick_scanner();
      CMD_START: begin
        if (mode != SCAN_IDLE) begin
          r.status = 1'b1;
        end else begin
          blank_digits();
          mode = SCAN_ARMED;
        end
      end
      CMD_STOP: begin
        if (mode == SCAN_IDLE) begin
          r.status = 1'b1;
        end else begin
          blank_digits();
          pin_conv    = 1'b0;
          pin_cathode = '0;
          pin_anodes  = '0;
          pin_point   = 1'b0;
          countdown   = '0;
          mode        = SCAN_IDLE;
        end
      end
      default: begin
        if (int'(c.digit_index) >= TubeCount || c.digit_value > MaxValue) begin
          r.status = 1'b1;
        end else begin
          digit_codes[c.digit_index] = {c.point_on, CathodeMap[4*c.digit_value +: 4]};
        end
      end
    endcase
    r.converter = pin_conv;
    r.cathode   = pin_cathode;
    r.anodes    = pin_anodes;
    r.point     = pin_point;
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [3:0] want,
                                      input logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scan_pins_t due, seen;
    cmd_t       taken;
    if (!rst_ni) begin
      reset_scanner();
      due_pins_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      compared_o   = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        seen = {res_mon.status, res_mon.converter_enable, res_mon.cathode_code,
                res_mon.anode_enables, res_mon.point_pin};
        if (due_pins_q.size() == 0) begin
          $display("%0t: result %0h with no command outstanding", $time, seen);
          fail_count_o++;
        end else begin
          due = due_pins_q.pop_front();
          compared_o++;
          check_field("status", 4'(due.status), 4'(seen.status));
          check_field("converter_enable", 4'(due.converter), 4'(seen.converter));
          check_field("cathode_code", due.cathode, seen.cathode);
          check_field("anode_enables", due.anodes, seen.anodes);
          check_field("point_pin", 4'(due.point), 4'(seen.point));
        end
      end
      // timing writes only land while stopped
      if (cfg_we_i && mode == SCAN_IDLE) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CATHODE_ON: wait_cathode   = cfg_data_i;
          CFG_ANODE_ON:   wait_anode_on  = cfg_data_i;
          CFG_ANODE_OFF:  wait_anode_off = cfg_data_i;
          default:        wait_blank     = cfg_data_i;
        endcase
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        taken = {cmd_mon.command, cmd_mon.digit_index, cmd_mon.digit_value, cmd_mon.point_on};
        due_pins_q.push_back(advance_scanner(taken));
      end
      pending_o = due_pins_q.size();
    end
  end

endmodule

>>> verif/nixie_multiplex_scanner_test.sv
module nixie_multiplex_scanner_test;
  import nms_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned TargetItems = 1275;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_idx_e            cfg_idx_i;
  logic [WaitW-1:0]    cfg_data_i;

  int                  fail_count, pending, compared;
  int unsigned         sent_count, settings_count, cycle_count;
  int unsigned         send_stretch, recv_stretch, rush_left;
  bit                  send_calm, recv_calm, hold_req, scan_on;

  nms_cmd_if cmd_ch ();
  nms_res_if res_ch ();

  nixie_multiplex_scanner dut (
    .clk_i,
    .rst_ni,
    .cmd_if    (cmd_ch),
    .res_if    (res_ch),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  nms_scan_checker u_checker (
    .clk_i,
    .rst_ni,
    .cmd_mon      (cmd_ch),
    .res_mon      (res_ch),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .compared_o   (compared)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Run stalled after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_cmd(input cmd_e op, input logic [1:0] idx, input logic [3:0] val,
                          input logic pt);
    int unsigned gap;
    if (send_stretch == 0) begin
      send_calm    = ($urandom_range(0, 3) == 0);
      send_stretch = $urandom_range(10, 80);
    end
    send_stretch--;
    gap = (send_calm || rush_left > 0) ? 0 : $urandom_range(0, 12);
    if (rush_left > 0) rush_left--;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.command     <= op;
    cmd_ch.digit_index <= idx;
    cmd_ch.digit_value <= val;
    cmd_ch.point_on    <= pt;
    do @(posedge clk_i); while (!(cmd_ch.valid && cmd_ch.ready));
    sent_count++;
    case (op)
      CMD_START: scan_on = 1'b1;
      CMD_STOP:  scan_on = 1'b0;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic send_op(input cmd_e op);
    send_cmd(op, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
             1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [WaitW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_timing(input logic [WaitW-1:0] cath, input logic [WaitW-1:0] aon,
                              input logic [WaitW-1:0] aoff, input logic [WaitW-1:0] blank);
    settings_count++;
    write_reg(CFG_CATHODE_ON, cath);
    write_reg(CFG_ANODE_ON, aon);
    write_reg(CFG_ANODE_OFF, aoff);
    write_reg(CFG_BLANK, blank);
  endtask

  function automatic logic [WaitW-1:0] pick_wait();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 13) return WaitW'($urandom_range(0, 3));
    if (roll < 17) return WaitW'($urandom_range(4, 12));
    if (roll < 19) return '0;
    return WaitW'($urandom_range(0, 65535));
  endfunction

  // mostly running scans fed with ticks, salted with digit updates and misplaced commands
  task automatic scan_burst(input int unsigned n, input bit with_hold);
    int unsigned roll;
    for (int unsigned i = 0; i < n; i++) begin
      if (with_hold && i == n / 2) begin
        hold_req  = 1'b1;
        rush_left = 24;
      end
      roll = $urandom_range(0, 99);
      if (!scan_on && roll < 80) send_op(CMD_START);
      else if (roll < 68) send_op(CMD_TICK);
      else if (roll < 84)
        send_cmd(CMD_SET, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 10)),
                 1'($urandom_range(0, 1)));
      else if (roll < 89)
        send_cmd(CMD_SET, 2'($urandom_range(0, 3)), 4'($urandom_range(11, 15)),
                 1'($urandom_range(0, 1)));
      else if (roll < 93) send_op(CMD_START);
      else if (roll < 96) send_op(CMD_STOP);
      else send_op(CMD_TICK);
    end
  endtask

  initial begin
    int unsigned stall;
    res_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (recv_stretch == 0) begin
        recv_calm    = ($urandom_range(0, 3) == 0);
        recv_stretch = $urandom_range(10, 120);
      end
      recv_stretch--;
      stall = recv_calm ? 0 : $urandom_range(0, 12);
      if (hold_req) begin
        stall    = 120;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_ch.valid && res_ch.ready));
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_CATHODE_ON;
    cfg_data_i         = '0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.command     = CMD_TICK;
    cmd_ch.digit_index = '0;
    cmd_ch.digit_value = '0;
    cmd_ch.point_on    = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    apply_timing(16'd0, 16'd1, 16'd2, 16'd3);
    send_op(CMD_STOP);
    send_op(CMD_TICK);
    send_cmd(CMD_SET, 2'd0, 4'd0, 1'b1);
    send_cmd(CMD_SET, 2'd1, 4'd9, 1'b0);
    send_cmd(CMD_SET, 2'd2, 4'd10, 1'b1);
    send_cmd(CMD_SET, 2'd3, 4'd15, 1'b1);
    send_cmd(CMD_SET, 2'd3, 4'd11, 1'b0);
    send_op(CMD_START);
    send_op(CMD_START);
    send_cmd(CMD_SET, 2'd0, 4'd5, 1'b1);
    send_cmd(CMD_SET, 2'd1, 4'd8, 1'b1);
    send_cmd(CMD_SET, 2'd3, 4'd3, 1'b0);
    repeat (12) send_op(CMD_TICK);
    send_op(CMD_STOP);
    drain();

    while (sent_count < TargetItems) begin
      if (settings_count == 1) apply_timing(16'd0, 16'd0, 16'd0, 16'd0);
      else if (settings_count == 2) apply_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      else apply_timing(pick_wait(), pick_wait(), pick_wait(), pick_wait());
      scan_burst(settings_count == 3 ? 30 : $urandom_range(80, 160), settings_count == 4);
      if (settings_count == 5) begin
        if (!scan_on) send_op(CMD_START);
        drain();
        write_reg(CFG_ANODE_OFF, 16'h5A5A);  // scanner running, write must not land
      end
      send_op(CMD_STOP);
      drain();
    end

    repeat (8) @(negedge clk_i);
    $display("Drove %0d commands under %0d timing settings; %0d results compared.",
             sent_count, settings_count, compared);
    $display("Included a long result back-pressure stretch and writes while scanning.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/nms_pkg.sv
src/nms_cmd_if.sv
src/nms_res_if.sv
src/nms_in_stage.sv
src/nms_cfg_regs.sv
src/nms_scan_core.sv
src/nixie_multiplex_scanner.sv
verif/nms_scan_checker.sv
verif/nixie_multiplex_scanner_test.sv
